// ===== hdl/oaie_pkg.sv =====
// shared codes and types for the ordered array insert/erase unit
// command and status codes, per-cell control struct; no dependencies
package oaie_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     rd_en;
    } t_cell_ctrl;

endpackage

// ===== hdl/ordered_array_insert_erase_unit.sv =====
// top level of the ordered array insert/erase unit
// decodes commands, drives a chain of oaie_cell and registers the result; uses oaie_pkg
//
// usage:
//   input channel  i_valid/o_ready carries i_command, i_value, i_position
//   output channel o_valid/i_ready carries o_read_value, o_count, o_status
//   every accepted item gives exactly one result item.
// the result is registered and shown in the cycle after the item is accepted.
// throughput: one item per cycle while results are taken; the cells that an insert or
//   erase moves shift as the item is accepted, and the next item sees the updated list.
// the input is ready whenever the output register is empty or is being
//   taken in the same cycle; a stalled receiver holds the result and stops
//   further items until it is taken.
// reset (synchronous, active low) empties the list and drops any pending
//   result; the cell contents are left as they are and are never read
//   before being written.
// a rejected item (range, full, empty) leaves the list unchanged and only
//   reports its status; reads past the count return zero.
module ordered_array_insert_erase_unit import oaie_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [CMD_W-1:0]           i_command,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [POS_W-1:0]           i_position,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [VALUE_W-1:0]  o_read_value,
    output logic [COUNT_W-1:0]         o_count,
    output logic [STATUS_W-1:0]        o_status
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic                       r_valid;
    logic signed [VALUE_W-1:0]  r_read_value;
    logic [COUNT_W-1:0]         r_count_out;
    logic [STATUS_W-1:0]        r_status;

    logic                       accept;
    logic [CMP_W-1:0]           cnt_e;
    logic [CMP_W-1:0]           pos_e;
    logic                       full;
    logic                       empty;
    logic [STATUS_W-1:0]        status;
    t_cell_op                   op;
    logic                       rd_ok;
    t_cell_ctrl                 ctrl;
    logic [CW-1:0]              sel;
    logic signed [WORD_BITS-1:0] value_w;
    logic [WORD_BITS-1:0]       words [DEPTH];
    logic [WORD_BITS-1:0]       rds   [DEPTH];
    logic [WORD_BITS-1:0]       rd_or;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign cnt_e   = CMP_W'(r_count);
    assign pos_e   = CMP_W'(i_position);
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign value_w = WORD_BITS'(i_value);

    always_comb begin
        status  = ST_OK;
        op      = CELL_HOLD;
        rd_ok   = 1'b0;
        n_count = r_count;
        sel     = CW'(i_position);
        unique case (i_command)
            CMD_APPEND: begin
                sel = r_count;
                if (full) begin
                    status = ST_FULL;
                end else begin
                    op      = CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_INSERT: begin
                if (pos_e > cnt_e) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    op      = CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            CMD_ERASE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (pos_e >= cnt_e) begin
                    status = ST_RANGE;
                end else begin
                    op      = CELL_ERASE;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_READ: begin
                if (pos_e >= cnt_e) begin
                    status = ST_RANGE;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            default: status = ST_OK;
        endcase
    end

    assign ctrl.op    = accept ? op : CELL_HOLD;
    assign ctrl.rd_en = rd_ok;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] left;
        logic [WORD_BITS-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = words[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = words[g+1];
        end
        oaie_cell #(
            .WORD_BITS (WORD_BITS),
            .CW        (CW),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_sel   (sel),
            .i_value (value_w),
            .i_left  (left),
            .i_right (right),
            .o_word  (words[g]),
            .o_rd    (rds[g])
        );
    end

    // only the addressed cell drives a nonzero read word
    always_comb begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_or = rd_or | rds[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_read_value <= VALUE_W'($signed(rd_or));
            r_count_out  <= COUNT_W'(n_count);
            r_status     <= status;
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_count      = r_count_out;
    assign o_status     = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> o_ready)
        else $error("input not ready with empty output register");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_count == COUNT_W'(DEPTH)))
        else $error("full status with count below depth");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with nonzero count");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_count == COUNT_W'(r_count)))
        else $error("reported count differs from stored count");

endmodule

// ===== hdl/oaie_cell.sv =====
// one storage cell of the ordered list chain
// holds one word, takes from its left or right neighbor on shifts; uses oaie_pkg
module oaie_cell import oaie_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int CW        = 5,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic [CW-1:0]        i_sel,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [WORD_BITS-1:0] i_left,
    input  logic [WORD_BITS-1:0] i_right,
    output logic [WORD_BITS-1:0] o_word,
    output logic [WORD_BITS-1:0] o_rd
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_ctrl.op)
            CELL_INSERT: begin
                if (MY_IDX == i_sel) begin
                    n_word = i_value;
                end else if (MY_IDX > i_sel) begin
                    n_word = i_left;
                end
            end
            CELL_ERASE: begin
                if (MY_IDX >= i_sel) begin
                    n_word = i_right;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_rd   = (i_ctrl.rd_en && MY_IDX == i_sel) ? r_word : '0;

endmodule

// ===== tb/oaie_checker.sv =====
// result checker for the ordered array insert/erase unit: watches both channels,
// keeps its own copy of the list and compares each result; uses oaie_pkg
`timescale 1ns / 1ps

module oaie_checker import oaie_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int MAX_REPORTS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [CMD_W-1:0]          i_command,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [POS_W-1:0]          i_position,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [VALUE_W-1:0] i_read_value,
    input  logic [COUNT_W-1:0]        i_count,
    input  logic [STATUS_W-1:0]       i_status,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        count;
        logic [STATUS_W-1:0]       status;
    } t_result;

    logic signed [VALUE_W-1:0] list_words [DEPTH];
    int unsigned               list_len     = 0;
    t_result                   result_q [$];
    int                        fails        = 0;
    int                        results_seen = 0;

    // applies one command to the shadow list and returns the result it should give
    function automatic t_result apply_command(logic [CMD_W-1:0] cmd,
                                              logic signed [VALUE_W-1:0] val,
                                              logic [POS_W-1:0] pos);
        t_result     res;
        int unsigned p;
        int unsigned i;
        res.read_value = '0;
        res.status     = ST_OK;
        p = 32'(pos);
        case (cmd)
            CMD_APPEND: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            CMD_INSERT: begin
                if (p > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = val;
                    list_len++;
                end
            end
            CMD_REMOVE: begin
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                    list_len--;
            end
            CMD_ERASE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            CMD_READ: begin
                if (p >= list_len)
                    res.status = ST_RANGE;
                else
                    res.read_value = list_words[p];
            end
            default: ;
        endcase
        res.count = COUNT_W'(list_len);
        return res;
    endfunction

    function automatic void note_failure(string what, logic [VALUE_W-1:0] want,
                                         logic [VALUE_W-1:0] got);
        if (fails < MAX_REPORTS)
            $display("[%0t] result %0d: %s expected %h got %h",
                     $realtime, results_seen, what, want, got);
        fails++;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            list_len = 0;
            result_q.delete();
        end else begin
            // a result taken here always belongs to an item taken at an earlier edge
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    note_failure("unexpected result, read_value", '0, i_read_value);
                end else begin
                    want = result_q.pop_front();
                    if (want.read_value !== i_read_value)
                        note_failure("read_value", want.read_value, i_read_value);
                    if (want.count !== i_count)
                        note_failure("count", VALUE_W'(want.count), VALUE_W'(i_count));
                    if (want.status !== i_status)
                        note_failure("status", VALUE_W'(want.status), VALUE_W'(i_status));
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready)
                result_q.insert(result_q.size(),
                                apply_command(i_command, i_value, i_position));
        end
        o_fail_count <= fails;
        o_pending    <= result_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// testbench top for the ordered array insert/erase unit: clock, reset, stimulus
// and verdict; depends on oaie_pkg, ordered_array_insert_erase_unit and oaie_checker
`timescale 1ns / 1ps

module tb import oaie_pkg::*;;

    localparam int              DEPTH        = DEPTH_DEF;
    localparam int              ITEMS_PHASE  = 350;
    localparam int              HOLD_CYCLES  = 200;
    localparam int              CYCLE_LIMIT  = 500000;
    localparam logic [CMD_W-1:0] CMD_LAST    = '1;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_valid    = 1'b0;
    logic                      o_ready;
    logic [CMD_W-1:0]          i_command  = '0;
    logic signed [VALUE_W-1:0] i_value    = '0;
    logic [POS_W-1:0]          i_position = '0;
    logic                      o_valid;
    logic                      i_ready    = 1'b0;
    logic signed [VALUE_W-1:0] o_read_value;
    logic [COUNT_W-1:0]        o_count;
    logic [STATUS_W-1:0]       o_status;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_gen       = 0;
    int cycles         = 0;
    int fill           = 0;
    bit growing        = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ordered_array_insert_erase_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    oaie_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_command    (i_command),
        .i_value      (i_value),
        .i_position   (i_position),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_read_value (o_read_value),
        .i_count      (o_count),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL ordered_array_insert_erase_unit");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off whenever hold_gen moves
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_gen) begin
                hold_seen = hold_gen;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // offers one item and returns at the edge where it is taken
    task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] val,
                             logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        // rough list length, only used to steer commands and positions
        case (cmd)
            CMD_APPEND: if (fill < DEPTH) fill++;
            CMD_INSERT: if (pos <= fill && fill < DEPTH) fill++;
            CMD_REMOVE: if (fill > 0) fill--;
            CMD_ERASE:  if (pos < fill) fill--;
            default: ;
        endcase
    endtask

    task automatic random_item();
        int                        r;
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] val;
        logic [POS_W-1:0]          pos;
        if (fill >= DEPTH && $urandom_range(3) == 0)
            growing = 1'b0;
        else if (fill == 0 && $urandom_range(3) == 0)
            growing = 1'b1;
        else if ($urandom_range(49) == 0)
            growing = !growing;
        r = $urandom_range(99);
        if (r < 4)
            cmd = CMD_W'($urandom_range(CMD_LAST, CMD_READ + 1));
        else if (r < 18)
            cmd = CMD_READ;
        else if ((r < 80) == growing)
            cmd = $urandom_range(1) ? CMD_APPEND : CMD_INSERT;
        else
            cmd = $urandom_range(1) ? CMD_REMOVE : CMD_ERASE;
        r = $urandom_range(99);
        if (r < 65)
            pos = POS_W'($urandom_range(fill, 0));
        else if (r < 80)
            pos = $urandom_range(1) ? POS_W'(fill) : POS_W'(fill - 1);
        else
            pos = POS_W'($urandom);
        r = $urandom_range(99);
        case (r)
            0:       val = {1'b1, {(VALUE_W-1){1'b0}}};
            1:       val = {1'b0, {(VALUE_W-1){1'b1}}};
            2:       val = '0;
            3:       val = '1;
            default: val = $urandom;
        endcase
        send_item(cmd, val, pos);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list rejections
        send_item(CMD_READ, $urandom, '0);
        send_item(CMD_REMOVE, $urandom, '0);
        send_item(CMD_ERASE, $urandom, '0);
        send_item(CMD_INSERT, $urandom, POS_W'(1));
        // extremes in, insert at the end and in the middle
        send_item(CMD_INSERT, {1'b1, {(VALUE_W-1){1'b0}}}, '0);
        send_item(CMD_APPEND, {1'b0, {(VALUE_W-1){1'b1}}}, '0);
        send_item(CMD_INSERT, '1, POS_W'(2));
        send_item(CMD_INSERT, 32'h5a5a_a5a5, POS_W'(1));
        send_item(CMD_READ, '0, '0);
        send_item(CMD_READ, '0, POS_W'(3));
        send_item(CMD_READ, '0, POS_W'(4));
        send_item(CMD_READ, '0, '1);
        send_item(CMD_ERASE, '0, POS_W'(4));
        send_item(CMD_ERASE, '0, POS_W'(1));
        send_item(CMD_ERASE, '0, POS_W'(2));
        send_item(CMD_REMOVE, '0, '0);
        for (int c = CMD_READ + 1; c <= CMD_LAST; c++)
            send_item(CMD_W'(c), $urandom, POS_W'($urandom));
        send_item(CMD_READ, '0, POS_W'(1));

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 83; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 83; end
                default: begin send_idle_pct <= 17; recv_stall_pct <= 17; end
            endcase
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                if (ph == 0 && n == ITEMS_PHASE / 2)
                    hold_gen <= hold_gen + 1;
                random_item();
            end
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (5) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS ordered_array_insert_erase_unit");
        else
            $display("FAIL ordered_array_insert_erase_unit");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/oaie_pkg.sv
hdl/oaie_cell.sv
hdl/ordered_array_insert_erase_unit.sv
tb/oaie_checker.sv
tb/tb.sv
